// ===== sv/crr_pkg.sv =====
// ----------------------------------------------------------------------------
// Ribbon tessellator package
// Shared widths, command and register codes, and the job record that the
// front end hands to the step engine.
// ----------------------------------------------------------------------------
package crr_pkg;
	localparam int COORD_W = 32;
	localparam int AXES = 6;
	localparam int COUNT_W = 11;
	localparam int STEP_W = 5;
	localparam int SCALE_W = 15;
	localparam int DEN_W = 16;
	localparam int CA_W = 33;
	localparam int CB_W = 36;
	localparam int P_W = 52;
	localparam int X_W = 54;
	localparam int Q_W = 36;
	localparam int RNUM_W = 16;
	localparam int RQ_W = 17;
	localparam int CH_W = 16;
	localparam int CHANNELS = 4;
	localparam int COLOR_W = 64;
	localparam int IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	localparam logic [IDX_W-1:0] REG_STEPS = 2'd0;
	localparam logic [IDX_W-1:0] REG_START = 2'd1;
	localparam logic [IDX_W-1:0] REG_END = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [AXES-1:0] point_t;

	typedef struct packed {
		logic frame;
		logic last_in;
		point_t [3:0] p;
		logic [COUNT_W-1:0] seg;
		logic [COUNT_W-1:0] n;
		logic [STEP_W-1:0] s;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;
endpackage

// ===== sv/crr_if.sv =====
// ----------------------------------------------------------------------------
// Ribbon tessellator channels
// Point input channel and vertex pair output channel, valid/ready.
// ----------------------------------------------------------------------------
interface crr_point_if;
	logic valid;
	logic ready;
	logic command;
	logic [crr_pkg::COUNT_W-1:0] point_count;
	logic signed [crr_pkg::COORD_W-1:0] tip_x;
	logic signed [crr_pkg::COORD_W-1:0] tip_y;
	logic signed [crr_pkg::COORD_W-1:0] tip_z;
	logic signed [crr_pkg::COORD_W-1:0] base_x;
	logic signed [crr_pkg::COORD_W-1:0] base_y;
	logic signed [crr_pkg::COORD_W-1:0] base_z;

	modport source(output valid, command, point_count, tip_x, tip_y, tip_z,
		base_x, base_y, base_z, input ready);
	modport sink(input valid, command, point_count, tip_x, tip_y, tip_z,
		base_x, base_y, base_z, output ready);
endinterface

interface crr_vertex_if;
	logic valid;
	logic ready;
	logic signed [crr_pkg::COORD_W-1:0] out_tip_x;
	logic signed [crr_pkg::COORD_W-1:0] out_tip_y;
	logic signed [crr_pkg::COORD_W-1:0] out_tip_z;
	logic signed [crr_pkg::COORD_W-1:0] out_base_x;
	logic signed [crr_pkg::COORD_W-1:0] out_base_y;
	logic signed [crr_pkg::COORD_W-1:0] out_base_z;
	logic [crr_pkg::CH_W-1:0] red;
	logic [crr_pkg::CH_W-1:0] green;
	logic [crr_pkg::CH_W-1:0] blue;
	logic [crr_pkg::CH_W-1:0] alpha;
	logic [crr_pkg::CH_W-1:0] ratio_u;
	logic last_of_run;

	modport source(output valid, out_tip_x, out_tip_y, out_tip_z, out_base_x,
		out_base_y, out_base_z, red, green, blue, alpha, ratio_u, last_of_run,
		input ready);
	modport sink(input valid, out_tip_x, out_tip_y, out_tip_z, out_base_x,
		out_base_y, out_base_z, red, green, blue, alpha, ratio_u, last_of_run,
		output ready);
endinterface

// ===== sv/crr_front.sv =====
// ----------------------------------------------------------------------------
// Ribbon tessellator front end
// Takes points, keeps the three-point window and trail index, and turns
// each transfer into zero, one or two segment jobs or a frame job.
// ----------------------------------------------------------------------------
module crr_front #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	crr_point_if.sink points,
	input logic [crr_pkg::STEP_W-1:0] steps,
	input logic queue_full,
	output crr_pkg::push_t push
);
	localparam int CW = crr_pkg::COUNT_W;
	localparam int SW = crr_pkg::STEP_W;
	localparam int PT_CAP = (MAX_POINTS > 2047) ? 2047 : MAX_POINTS;
	localparam int ST_CAP = (MAX_STEPS > 31) ? 31 : MAX_STEPS;
	localparam logic [CW-1:0] PT_CAP_V = CW'(PT_CAP);
	localparam logic [SW-1:0] ST_CAP_V = SW'(ST_CAP);

	logic accept;
	logic is_point;
	logic [CW-1:0] n_c;
	logic [SW-1:0] s_c;
	logic last_c;
	logic emit_c;
	crr_pkg::point_t pt_c;
	crr_pkg::point_t [2:0] w_c;
	crr_pkg::point_t [2:0] window_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pend_seg_q;
	logic [CW-1:0] pend_n_q;
	logic [SW-1:0] pend_s_q;
	logic pend_q;

	assign points.ready = !pend_q && !queue_full;
	assign accept = points.valid && points.ready;
	assign is_point = points.command == crr_pkg::CMD_POINT;
	assign pt_c = {points.base_z, points.base_y, points.base_x,
		points.tip_z, points.tip_y, points.tip_x};

	always_comb begin
		n_c = (points.point_count > PT_CAP_V) ? PT_CAP_V : points.point_count;
		if (steps == '0) begin
			s_c = SW'(1);
		end else if (steps > ST_CAP_V) begin
			s_c = ST_CAP_V;
		end else begin
			s_c = steps;
		end
		last_c = ({1'b0, idx_q} + (CW+1)'(1)) >= {1'b0, n_c};
		w_c = (idx_q == '0) ? {pt_c, pt_c, pt_c} : window_q;
		emit_c = (n_c >= CW'(4)) && (idx_q >= CW'(2));
	end

	always_comb begin
		push = '0;
		if (pend_q) begin
			push.valid = !queue_full;
			push.job.last_in = 1'b1;
			push.job.p = {window_q[2], window_q[2], window_q[1], window_q[0]};
			push.job.seg = pend_seg_q;
			push.job.n = pend_n_q;
			push.job.s = pend_s_q;
		end else if (accept) begin
			if (!is_point) begin
				push.valid = 1'b1;
				push.job.frame = 1'b1;
			end else if (emit_c) begin
				push.valid = 1'b1;
				push.job.last_in = !last_c;
				push.job.p = {pt_c, w_c[2], w_c[1], w_c[0]};
				push.job.seg = idx_q - CW'(2);
				push.job.n = n_c;
				push.job.s = s_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !queue_full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (!is_point) begin
					idx_q <= '0;
				end else begin
					idx_q <= last_c ? '0 : idx_q + CW'(1);
					pend_q <= emit_c && last_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_point) begin
			window_q <= {pt_c, w_c[2], w_c[1]};
			pend_seg_q <= idx_q - CW'(1);
			pend_n_q <= n_c;
			pend_s_q <= s_c;
		end
	end
endmodule

// ===== sv/crr_queue.sv =====
// ----------------------------------------------------------------------------
// Ribbon tessellator job queue
// Short register queue between the front end and the step engine.
// ----------------------------------------------------------------------------
module crr_queue (
	input logic clk,
	input logic arst_n,
	input crr_pkg::push_t push,
	input logic pop,
	output crr_pkg::job_t head,
	output logic head_valid,
	output logic full
);
	localparam int D = crr_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);

	crr_pkg::job_t mem_q [D];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(D);
	assign head_valid = cnt_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (!push.valid && pop) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.job;
		end
	end

`ifndef SYNTH
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (!full || pop))
		else $error("job pushed into a full queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(D))
		else $error("queue count beyond its depth");
`endif
endmodule

// ===== sv/crr_back.sv =====
// ----------------------------------------------------------------------------
// Ribbon tessellator step engine
// Runs one job at a time: per step it checks the vertex budget, evaluates
// six spline lanes and the texture ratio through bit-serial dividers, lerps
// the color and loads the output register.
// ----------------------------------------------------------------------------
module crr_back #(
	parameter int VERTEX_CAPACITY = 4096
) (
	input logic clk,
	input logic arst_n,
	input crr_pkg::job_t head,
	input logic head_valid,
	output logic pop,
	input logic [crr_pkg::COLOR_W-1:0] start_color,
	input logic [crr_pkg::COLOR_W-1:0] end_color,
	crr_vertex_if.source vertices
);
	localparam int AXES = crr_pkg::AXES;
	localparam int SW = crr_pkg::STEP_W;
	localparam int CW = crr_pkg::COUNT_W;
	localparam int SCW = crr_pkg::SCALE_W;
	localparam int DW = crr_pkg::DEN_W;
	localparam int CAW = crr_pkg::CA_W;
	localparam int CBW = crr_pkg::CB_W;
	localparam int PW = crr_pkg::P_W;
	localparam int XW = crr_pkg::X_W;
	localparam int QW = crr_pkg::Q_W;
	localparam int RNW = crr_pkg::RNUM_W;
	localparam int RQW = crr_pkg::RQ_W;
	localparam int HW = crr_pkg::CH_W;
	localparam int NCH = crr_pkg::CHANNELS;
	localparam int KW = $clog2(QW);
	localparam int VW = $clog2(VERTEX_CAPACITY) + 2;
	localparam logic [VW-1:0] CAP_V = VW'(VERTEX_CAPACITY);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_COEF  = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_MUL   = 9'b000001000,
		S_SUM   = 9'b000010000,
		S_NEG   = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_COL   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [VW-1:0] vused_q;
	logic full_q;
	logic [SW-1:0] j_q;
	logic [KW-1:0] cnt_q;
	logic out_valid_q;

	crr_pkg::coord_t a1_q [AXES];
	logic signed [CAW-1:0] ca_q [AXES];
	logic signed [CBW-1:0] cb_q [AXES];
	logic signed [CBW-1:0] cc_q [AXES];
	logic signed [PW-1:0] pa_q [AXES];
	logic signed [PW-1:0] pb_q [AXES];
	logic signed [PW-1:0] pc_q [AXES];
	logic signed [XW-1:0] x_q [AXES];
	logic neg_q [AXES];
	logic [DW-1:0] rem_q [AXES];
	logic [QW-1:0] sh_q [AXES];
	crr_pkg::coord_t v_q [AXES];
	logic [SCW-1:0] js2_q, j2s_q, j3_q, s3_q;
	logic [DW-1:0] den_q;
	logic [RNW-1:0] rnum_q, rden_q;
	logic rsat_q;
	logic [RQW-1:0] rrem_q, rsh_q;
	logic [HW-1:0] u_q;
	logic signed [2*RQW-1:0] cprod_q [NCH];
	logic last_q;

	crr_pkg::coord_t out_pos_q [AXES];
	logic [HW-1:0] out_col_q [NCH];
	logic [HW-1:0] out_u_q;
	logic out_last_q;

	logic signed [CAW-1:0] ca_c [AXES];
	logic signed [CBW-1:0] cb_c [AXES];
	logic signed [CBW-1:0] cc_c [AXES];
	logic [2*SW-1:0] jj_c, ss_c;
	logic [SCW-1:0] js2_c, j2s_c, j3_c, s3_c;
	logic fail_c;
	logic step_last_c;
	logic out_load;
	logic signed [XW-1:0] n_c [AXES];
	logic [DW-1:0] rem_n_c [AXES];
	logic qbit_c [AXES];
	logic [RQW-1:0] rrem_n_c;
	logic rbit_c;
	crr_pkg::coord_t v_c [AXES];
	logic [HW-1:0] u_c;
	logic [HW-1:0] col_c [NCH];

	always_comb begin
		logic signed [CBW-1:0] e0, e1, e2, e3;
		for (int c = 0; c < AXES; c++) begin
			e0 = CBW'($signed(head.p[0][c]));
			e1 = CBW'($signed(head.p[1][c]));
			e2 = CBW'($signed(head.p[2][c]));
			e3 = CBW'($signed(head.p[3][c]));
			ca_c[c] = CAW'(e2 - e0);
			cb_c[c] = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			cc_c[c] = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;
		end
	end

	always_comb begin
		jj_c = (2*SW)'(j_q) * (2*SW)'(j_q);
		ss_c = (2*SW)'(head.s) * (2*SW)'(head.s);
		js2_c = SCW'(j_q) * SCW'(ss_c);
		j2s_c = SCW'(jj_c) * SCW'(head.s);
		j3_c = SCW'(jj_c) * SCW'(j_q);
		s3_c = SCW'(ss_c) * SCW'(head.s);
		fail_c = full_q || ((vused_q + VW'(2)) >= CAP_V);
		step_last_c = ((j_q == head.s - SW'(1)) && head.last_in)
			|| ((vused_q + VW'(4)) >= CAP_V);
	end

	always_comb begin
		logic [DW:0] r2, d2;
		logic [RQW:0] rr2, rd2;
		for (int c = 0; c < AXES; c++) begin
			n_c[c] = x_q[c][XW-1]
				? (-x_q[c] + XW'($signed({1'b0, den_q})) - XW'(1)) : x_q[c];
			r2 = {rem_q[c], sh_q[c][QW-1]};
			d2 = {1'b0, den_q};
			qbit_c[c] = r2 >= d2;
			rem_n_c[c] = qbit_c[c] ? DW'(r2 - d2) : r2[DW-1:0];
		end
		rr2 = {rrem_q, rsh_q[RQW-1]};
		rd2 = {1'b0, rden_q, 1'b0};
		rbit_c = rr2 >= rd2;
		rrem_n_c = rbit_c ? RQW'(rr2 - rd2) : rr2[RQW-1:0];
	end

	always_comb begin
		logic signed [QW:0] qs;
		logic signed [QW+1:0] vs;
		for (int c = 0; c < AXES; c++) begin
			qs = neg_q[c] ? -$signed({1'b0, sh_q[c]}) : $signed({1'b0, sh_q[c]});
			vs = (QW+2)'(a1_q[c]) + (QW+2)'(qs);
			if (vs[QW+1:31] == '0 || vs[QW+1:31] == '1) begin
				v_c[c] = vs[31:0];
			end else begin
				v_c[c] = vs[QW+1] ? 32'sh80000000 : 32'sh7fffffff;
			end
		end
		if (rsat_q || rsh_q[RQW-1]) begin
			u_c = '1;
		end else begin
			u_c = rsh_q[HW-1:0];
		end
	end

	always_comb begin
		logic signed [2*RQW:0] t;
		logic signed [HW+2:0] cv;
		for (int c = 0; c < NCH; c++) begin
			t = (2*RQW+1)'(cprod_q[c]) + (2*RQW+1)'(32768);
			t = t >>> 16;
			cv = (HW+3)'($signed({1'b0, start_color[c*HW +: HW]})) + t[HW+2:0];
			if (cv < 0) begin
				col_c[c] = '0;
			end else if (cv > (HW+3)'(65535)) begin
				col_c[c] = '1;
			end else begin
				col_c[c] = cv[HW-1:0];
			end
		end
	end

	assign out_load = (state_q == S_COL) && (!out_valid_q || vertices.ready);

	always_comb begin
		pop = 1'b0;
		case (state_q)
			S_IDLE: pop = head_valid && head.frame;
			S_SETUP: pop = fail_c;
			S_COL: pop = out_load && (j_q == head.s - SW'(1));
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vused_q <= '0;
			full_q <= 1'b0;
			j_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (vertices.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						if (head.frame) begin
							vused_q <= '0;
							full_q <= 1'b0;
						end else begin
							j_q <= '0;
							state_q <= S_COEF;
						end
					end
				end
				S_COEF: state_q <= S_SETUP;
				S_SETUP: begin
					if (fail_c) begin
						full_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						vused_q <= vused_q + VW'(2);
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_NEG;
				S_NEG: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(QW - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_COL;
				S_COL: begin
					if (out_load) begin
						if (j_q == head.s - SW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + SW'(1);
							state_q <= S_SETUP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_COEF: begin
				for (int c = 0; c < AXES; c++) begin
					a1_q[c] <= head.p[1][c];
					ca_q[c] <= ca_c[c];
					cb_q[c] <= cb_c[c];
					cc_q[c] <= cc_c[c];
				end
			end
			S_SETUP: begin
				js2_q <= js2_c;
				j2s_q <= j2s_c;
				j3_q <= j3_c;
				s3_q <= s3_c;
				den_q <= {s3_c, 1'b0};
				last_q <= step_last_c;
			end
			S_MUL: begin
				for (int c = 0; c < AXES; c++) begin
					pa_q[c] <= PW'(ca_q[c]) * PW'($signed({1'b0, js2_q}));
					pb_q[c] <= PW'(cb_q[c]) * PW'($signed({1'b0, j2s_q}));
					pc_q[c] <= PW'(cc_q[c]) * PW'($signed({1'b0, j3_q}));
				end
				rnum_q <= RNW'(head.seg) * RNW'(head.s) + RNW'(j_q);
				rden_q <= RNW'(head.n - CW'(1)) * RNW'(head.s);
			end
			S_SUM: begin
				for (int c = 0; c < AXES; c++) begin
					x_q[c] <= XW'(pa_q[c]) + XW'(pb_q[c]) + XW'(pc_q[c])
						+ XW'($signed({1'b0, s3_q}));
				end
				rsat_q <= rnum_q >= rden_q;
				rrem_q <= RQW'(rnum_q);
				rsh_q <= RQW'(rden_q);
			end
			S_NEG: begin
				for (int c = 0; c < AXES; c++) begin
					neg_q[c] <= x_q[c][XW-1];
					rem_q[c] <= n_c[c][QW+DW-1:QW];
					sh_q[c] <= n_c[c][QW-1:0];
				end
			end
			S_DIV: begin
				for (int c = 0; c < AXES; c++) begin
					rem_q[c] <= rem_n_c[c];
					sh_q[c] <= {sh_q[c][QW-2:0], qbit_c[c]};
				end
				if (cnt_q < KW'(RQW)) begin
					rrem_q <= rrem_n_c;
					rsh_q <= {rsh_q[RQW-2:0], rbit_c};
				end
			end
			S_FIN: begin
				for (int c = 0; c < AXES; c++) begin
					v_q[c] <= v_c[c];
				end
				u_q <= u_c;
				for (int c = 0; c < NCH; c++) begin
					cprod_q[c] <= ((2*RQW)'($signed({1'b0, end_color[c*HW +: HW]}))
						- (2*RQW)'($signed({1'b0, start_color[c*HW +: HW]})))
						* (2*RQW)'($signed({1'b0, u_c}));
				end
			end
			default: ;
		endcase
		if (out_load) begin
			for (int c = 0; c < AXES; c++) begin
				out_pos_q[c] <= v_q[c];
			end
			for (int c = 0; c < NCH; c++) begin
				out_col_q[c] <= col_c[c];
			end
			out_u_q <= u_q;
			out_last_q <= last_q;
		end
	end

	assign vertices.valid = out_valid_q;
	assign vertices.out_tip_x = out_pos_q[0];
	assign vertices.out_tip_y = out_pos_q[1];
	assign vertices.out_tip_z = out_pos_q[2];
	assign vertices.out_base_x = out_pos_q[3];
	assign vertices.out_base_y = out_pos_q[4];
	assign vertices.out_base_z = out_pos_q[5];
	assign vertices.red = out_col_q[0];
	assign vertices.green = out_col_q[1];
	assign vertices.blue = out_col_q[2];
	assign vertices.alpha = out_col_q[3];
	assign vertices.ratio_u = out_u_q;
	assign vertices.last_of_run = out_last_q;

`ifndef SYNTH
	a_budget_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vused_q < CAP_V)
		else $error("vertex count reached the capacity");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> state_q != S_COL)
		else $error("result produced after the budget ran out");
	a_div_before_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> $past(state_q) == S_DIV)
		else $error("result stage entered without a finished division");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		vused_q != $past(vused_q) |-> (vused_q == $past(vused_q) + VW'(2)
		|| vused_q == '0))
		else $error("vertex count moved by other than one pair");
`endif
endmodule

// ===== sv/catmull_rom_ribbon_tessellator.sv =====
// Job path: a point job is written into the job queue on its transfer; per job the step
// engine loads coefficients, then runs each step through setup, multiply, sum, negate,
// divide, finish and color, holding in color while the output is not taken. The engine
// takes no new job before its last step loads; the bit-serial dividers dominate each step.
// Reset: registers take their reset values, index and vertex budget clear at once; the
// window is refilled by the first point of each trail, so there is no clearing pass.
// ----------------------------------------------------------------------------
// Catmull-Rom ribbon tessellator
// Top level: configuration registers, front end, job queue and step engine.
// ----------------------------------------------------------------------------
module catmull_rom_ribbon_tessellator #(
	parameter int MAX_POINTS = 1024,
	parameter int VERTEX_CAPACITY = 4096,
	parameter int MAX_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	crr_point_if.sink points,
	crr_vertex_if.source vertices,
	input logic write_enable,
	input logic [crr_pkg::IDX_W-1:0] register_index,
	input logic [crr_pkg::COLOR_W-1:0] write_data
);
	localparam int SW = crr_pkg::STEP_W;

	logic [SW-1:0] steps_q;
	logic [crr_pkg::COLOR_W-1:0] start_color_q;
	logic [crr_pkg::COLOR_W-1:0] end_color_q;
	crr_pkg::push_t push;
	crr_pkg::job_t head;
	logic head_valid;
	logic queue_full;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= SW'(4);
			start_color_q <= '1;
			end_color_q <= '0;
		end else if (write_enable) begin
			case (register_index)
				crr_pkg::REG_STEPS: steps_q <= write_data[SW-1:0];
				crr_pkg::REG_START: start_color_q <= write_data;
				crr_pkg::REG_END: end_color_q <= write_data;
				default: ;
			endcase
		end
	end

	crr_front #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_STEPS(MAX_STEPS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.points(points),
		.steps(steps_q),
		.queue_full(queue_full),
		.push(push)
	);

	crr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head(head),
		.head_valid(head_valid),
		.full(queue_full)
	);

	crr_back #(
		.VERTEX_CAPACITY(VERTEX_CAPACITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.start_color(start_color_q),
		.end_color(end_color_q),
		.vertices(vertices)
	);
endmodule

// ===== bench/tb_catmull_rom_ribbon_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ribbon tessellator testbench
// Drives trail points and frame commands through the point channel and checks
// every vertex pair against an in-bench spline predictor. It covers short and
// clamped trails, count changes mid-trail, the vertex budget and several
// register settings, under random idling on both channels.
// ----------------------------------------------------------------------------
typedef crr_pkg::coord_t axes_t [crr_pkg::AXES];

typedef struct {
	crr_pkg::coord_t pos [crr_pkg::AXES];
	logic [crr_pkg::CH_W-1:0] chan [crr_pkg::CHANNELS];
	logic [crr_pkg::CH_W-1:0] u;
	logic last;
} vertex_pair_t;

class ribbon_scoreboard;
	localparam int MAX_POINTS = 1024;
	localparam int VERTEX_CAPACITY = 4096;
	localparam int MAX_STEPS = 16;

	logic [4:0] steps_reg;
	logic [63:0] start_color;
	logic [63:0] end_color;
	axes_t window [3];
	int unsigned pt_idx;
	int unsigned verts_used;
	bit budget_hit;
	vertex_pair_t expected_pairs [$];
	int mismatches;
	int pairs_checked;

	function new();
		steps_reg = 5'd4;
		start_color = '1;
		end_color = '0;
		foreach (window[k, c]) window[k][c] = '0;
		pt_idx = 0;
		verts_used = 0;
		budget_hit = 0;
		mismatches = 0;
		pairs_checked = 0;
	endfunction

	function void write_reg(logic [crr_pkg::IDX_W-1:0] idx, logic [63:0] data);
		case (idx)
			crr_pkg::REG_STEPS: steps_reg = data[4:0];
			crr_pkg::REG_START: start_color = data;
			crr_pkg::REG_END: end_color = data;
			default: ;
		endcase
	endfunction

	function longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	function crr_pkg::coord_t spline(longint a0, longint a1, longint a2, longint a3,
		longint j, longint s);
		longint s3, num, v;
		s3 = s * s * s;
		num = 2 * a1 * s3 + (a2 - a0) * j * s * s
			+ (2 * a0 - 5 * a1 + 4 * a2 - a3) * j * j * s
			+ (-a0 + 3 * a1 - 3 * a2 + a3) * j * j * j;
		v = floor_quot(num + s3, 2 * s3);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function void segment(axes_t p0, axes_t p1, axes_t p2, axes_t p3,
		int unsigned seg, int unsigned n, int unsigned s, ref vertex_pair_t run [$]);
		vertex_pair_t vp;
		longint unsigned num, den, u;
		longint sc, ec, v;
		for (int unsigned j = 0; j < s; j++) begin
			if (budget_hit) break;
			if (verts_used + 2 >= VERTEX_CAPACITY) begin
				budget_hit = 1;
				break;
			end
			for (int c = 0; c < crr_pkg::AXES; c++)
				vp.pos[c] = spline(p0[c], p1[c], p2[c], p3[c], j, s);
			num = longint'(seg) * s + j;
			den = longint'(n - 1) * s;
			u = (num * 131072 + den) / (2 * den);
			if (u > 65535) u = 65535;
			for (int c = 0; c < crr_pkg::CHANNELS; c++) begin
				sc = longint'(start_color[16 * c +: 16]);
				ec = longint'(end_color[16 * c +: 16]);
				v = sc + floor_quot((ec - sc) * longint'(u) + 32768, 65536);
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				vp.chan[c] = v[15:0];
			end
			vp.u = u[15:0];
			vp.last = 0;
			run = {run, vp};
			verts_used += 2;
		end
	endfunction

	function void note_input(logic cmd, logic [crr_pkg::COUNT_W-1:0] cnt, axes_t pt);
		vertex_pair_t run [$];
		axes_t w [3];
		int unsigned n, s, idx;
		bit is_last;
		if (cmd == crr_pkg::CMD_FRAME) begin
			verts_used = 0;
			budget_hit = 0;
			pt_idx = 0;
			return;
		end
		n = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
		s = (steps_reg == 0) ? 1 : ((steps_reg > MAX_STEPS) ? MAX_STEPS : steps_reg);
		idx = pt_idx;
		is_last = (idx + 1 >= n);
		if (idx == 0)
			for (int k = 0; k < 3; k++) window[k] = pt;
		w = window;
		if (n >= 4 && idx >= 2) begin
			segment(w[0], w[1], w[2], pt, idx - 2, n, s, run);
			if (is_last) segment(w[1], w[2], pt, pt, idx - 1, n, s, run);
		end
		window[0] = w[1];
		window[1] = w[2];
		window[2] = pt;
		pt_idx = is_last ? 0 : ((idx + 1) & 11'h7FF);
		if (run.size() > 0) run[run.size() - 1].last = 1;
		expected_pairs = {expected_pairs, run};
	endfunction

	function void check_result(vertex_pair_t act);
		vertex_pair_t exp_vp;
		string axis_names [crr_pkg::AXES] = '{"tip_x", "tip_y", "tip_z",
			"base_x", "base_y", "base_z"};
		string chan_names [crr_pkg::CHANNELS] = '{"red", "green", "blue", "alpha"};
		pairs_checked++;
		if (expected_pairs.size() == 0) begin
			$display("%0t: unexpected vertex pair, expected none, actual u=%0d",
				$realtime, act.u);
			mismatches++;
			return;
		end
		exp_vp = expected_pairs.pop_front();
		for (int c = 0; c < crr_pkg::AXES; c++)
			if (act.pos[c] !== exp_vp.pos[c]) begin
				$display("%0t: %s expected %0d actual %0d", $realtime, axis_names[c],
					exp_vp.pos[c], act.pos[c]);
				mismatches++;
			end
		for (int c = 0; c < crr_pkg::CHANNELS; c++)
			if (act.chan[c] !== exp_vp.chan[c]) begin
				$display("%0t: %s expected %0d actual %0d", $realtime, chan_names[c],
					exp_vp.chan[c], act.chan[c]);
				mismatches++;
			end
		if (act.u !== exp_vp.u) begin
			$display("%0t: ratio_u expected %0d actual %0d", $realtime, exp_vp.u, act.u);
			mismatches++;
		end
		if (act.last !== exp_vp.last) begin
			$display("%0t: last_of_run expected %0b actual %0b", $realtime,
				exp_vp.last, act.last);
			mismatches++;
		end
	endfunction
endclass

module tb_catmull_rom_ribbon_tessellator;
	localparam int CW = crr_pkg::COUNT_W;
	localparam logic [crr_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic write_enable;
	logic [crr_pkg::IDX_W-1:0] register_index;
	logic [crr_pkg::COLOR_W-1:0] write_data;
	int send_idle_pct;
	int recv_idle_pct;
	int cycles = 0;
	int points_sent;
	int frames_sent;
	ribbon_scoreboard sb;

	crr_point_if pif();
	crr_vertex_if vif();

	catmull_rom_ribbon_tessellator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(pif),
		.vertices(vif),
		.write_enable(write_enable),
		.register_index(register_index),
		.write_data(write_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		vertex_pair_t act;
		if (arst_n && vif.valid && vif.ready) begin
			act.pos[0] = vif.out_tip_x;
			act.pos[1] = vif.out_tip_y;
			act.pos[2] = vif.out_tip_z;
			act.pos[3] = vif.out_base_x;
			act.pos[4] = vif.out_base_y;
			act.pos[5] = vif.out_base_z;
			act.chan[0] = vif.red;
			act.chan[1] = vif.green;
			act.chan[2] = vif.blue;
			act.chan[3] = vif.alpha;
			act.u = vif.ratio_u;
			act.last = vif.last_of_run;
			sb.check_result(act);
		end
		vif.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic crr_pkg::coord_t rand_coord();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(1 << 20)) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic axes_t rand_point();
		axes_t pt;
		foreach (pt[c]) pt[c] = rand_coord();
		return pt;
	endfunction

	function automatic axes_t flat_point(crr_pkg::coord_t v);
		axes_t pt;
		foreach (pt[c]) pt[c] = v;
		return pt;
	endfunction

	task automatic send(logic cmd, logic [CW-1:0] cnt, axes_t pt);
		pif.valid <= 1'b1;
		pif.command <= cmd;
		pif.point_count <= cnt;
		pif.tip_x <= pt[0];
		pif.tip_y <= pt[1];
		pif.tip_z <= pt[2];
		pif.base_x <= pt[3];
		pif.base_y <= pt[4];
		pif.base_z <= pt[5];
		@(posedge clk);
		while (!pif.ready) @(posedge clk);
		sb.note_input(cmd, cnt, pt);
		if (cmd == crr_pkg::CMD_POINT) points_sent++;
		else frames_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			pif.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_point(logic [CW-1:0] cnt, axes_t pt);
		send(crr_pkg::CMD_POINT, cnt, pt);
	endtask

	task automatic new_frame();
		send(crr_pkg::CMD_FRAME, CW'($urandom), rand_point());
	endtask

	task automatic drain();
		pif.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pairs.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [crr_pkg::IDX_W-1:0] idx,
		logic [crr_pkg::COLOR_W-1:0] data);
		write_enable <= 1'b1;
		register_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_enable <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic random_trails(int items);
		int sent;
		int len;
		logic [CW-1:0] cnt;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(19))
				0: begin
					new_frame();
					continue;
				end
				1, 2: cnt = CW'($urandom_range(3));
				3: cnt = CW'($urandom_range(512, 2047));
				default: cnt = CW'($urandom_range(4, 10));
			endcase
			len = (cnt >= 4 && cnt <= 10) ? int'(cnt) : int'($urandom_range(1, 6));
			if ($urandom_range(9) == 0) len = int'($urandom_range(1, len));
			for (int i = 0; i < len; i++) begin
				send_point(($urandom_range(29) == 0) ? CW'($urandom_range(2047)) : cnt,
					rand_point());
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		points_sent = 0;
		frames_sent = 0;
		send_idle_pct = 28;
		recv_idle_pct = 59;
		arst_n <= 1'b0;
		write_enable <= 1'b0;
		register_index <= '0;
		write_data <= '0;
		pif.valid <= 1'b0;
		pif.command <= crr_pkg::CMD_FRAME;
		pif.point_count <= '0;
		pif.tip_x <= '0;
		pif.tip_y <= '0;
		pif.tip_z <= '0;
		pif.base_x <= '0;
		pif.base_y <= '0;
		pif.base_z <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short trails, extreme coordinates and a clamped count.
		new_frame();
		send_point(11'd0, rand_point());
		send_point(11'd2, rand_point());
		send_point(11'd2, rand_point());
		send_point(11'd4, flat_point(32'sh7FFFFFFF));
		send_point(11'd4, flat_point(32'sh80000000));
		send_point(11'd4, flat_point(32'sh00000000));
		send_point(11'd4, flat_point(32'sh7FFFFFFF));
		for (int i = 0; i < 3; i++) send_point(11'd2047, rand_point());
		send_point(11'd4, rand_point());
		// The count drops below the index, so the ratio saturates.
		for (int i = 0; i < 6; i++) send_point(11'd8, rand_point());
		send_point(11'd4, rand_point());
		send_point(11'd1024, rand_point());
		send_point(11'd1024, rand_point());
		new_frame();
		drain();

		write_reg(crr_pkg::REG_STEPS, 64'd0);
		write_reg(crr_pkg::REG_START, '1);
		write_reg(crr_pkg::REG_END, '0);
		random_trails(70);
		drain();

		send_idle_pct = 59;
		recv_idle_pct = 28;
		write_reg(crr_pkg::REG_STEPS, 64'd31);
		write_reg(crr_pkg::REG_START, '0);
		write_reg(crr_pkg::REG_END, '1);
		random_trails(50);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(crr_pkg::REG_STEPS, 64'd1);
		write_reg(crr_pkg::REG_START, {$urandom, $urandom});
		write_reg(crr_pkg::REG_END, {$urandom, $urandom});
		write_reg(REG_SPARE, '1);
		random_trails(80);
		drain();

		// A long trail at full steps runs out of vertex budget.
		write_reg(crr_pkg::REG_STEPS, 64'd16);
		write_reg(crr_pkg::REG_START, {$urandom, $urandom});
		new_frame();
		for (int i = 0; i < 140; i++) send_point(11'd1024, rand_point());
		new_frame();
		send_point(11'd4, rand_point());
		drain();

		for (int p = 0; p < 3; p++) begin
			write_reg(crr_pkg::REG_STEPS, 64'($urandom_range(2, 6)));
			write_reg(crr_pkg::REG_START, {$urandom, $urandom});
			write_reg(crr_pkg::REG_END, {$urandom, $urandom});
			random_trails(20);
			drain();
		end

		$display("Run covered %0d points and %0d frame commands, %0d vertex pairs checked",
			points_sent, frames_sent, sb.pairs_checked);
		$display("across step counts from zero to 31 and the color extremes.");
		if (sb.mismatches == 0 && sb.expected_pairs.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
sv/crr_pkg.sv
sv/crr_if.sv
sv/crr_front.sv
sv/crr_queue.sv
sv/crr_back.sv
sv/catmull_rom_ribbon_tessellator.sv
bench/tb_catmull_rom_ribbon_tessellator.sv
